// File: design/hts_pkg.sv
// Shared types and constants for the hysteresis thermostat block.
package hts_pkg;

  localparam int TEMP_W  = 16;
  localparam int TIME_W  = 32;
  localparam int BAND_W  = 8;
  localparam int DELAY_W = 16;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;

  // Register indexes on the write port
  localparam logic [IDX_W-1:0] REG_TARGET    = 3'd0;
  localparam logic [IDX_W-1:0] REG_BAND      = 3'd1;
  localparam logic [IDX_W-1:0] REG_LOW       = 3'd2;
  localparam logic [IDX_W-1:0] REG_HIGH      = 3'd3;
  localparam logic [IDX_W-1:0] REG_MIN_OFF   = 3'd4;

  // Register reset values
  localparam logic signed [TEMP_W-1:0] TARGET_RST  = 16'sd608;
  localparam logic [BAND_W-1:0]        BAND_RST    = 8'd8;
  localparam logic signed [TEMP_W-1:0] LOW_RST     = 16'sd512;
  localparam logic signed [TEMP_W-1:0] HIGH_RST    = 16'sd2960;
  localparam logic [DELAY_W-1:0]       MIN_OFF_RST = 16'd60;

  // Sample status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_READ_ERR = 2'd1;
  localparam logic [1:0] STATUS_RANGE    = 2'd2;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature_sample;
    logic                     read_ok;
    logic [TIME_W-1:0]        now_seconds;
  } in_item_t;

  typedef struct packed {
    logic                     drive_on;
    logic                     drive_known;
    logic                     short_cycle_blocked;
    logic [1:0]               sample_status;
    logic signed [TEMP_W-1:0] held_temperature;
  } out_item_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] target_temp;
    logic [BAND_W-1:0]        hysteresis_band;
    logic signed [TEMP_W-1:0] valid_low_bound;
    logic signed [TEMP_W-1:0] valid_high_bound;
    logic [DELAY_W-1:0]       min_off_seconds;
  } cfg_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] last_good_temp;
    logic                     relay_state;
    logic                     decision_made;
    logic [TIME_W-1:0]        off_timestamp;
    logic                     off_timestamp_valid;
  } ctl_state_t;

endpackage

// File: design/hts_decide.sv
// Sample filter and relay decision for one beat, from current state to next state.
module hts_decide
  import hts_pkg::*;
(
  input  cfg_t       cfg,
  input  ctl_state_t cur,
  input  in_item_t   item,
  output ctl_state_t nxt,
  output out_item_t  result
);

  logic                     in_window;
  logic [1:0]               status;
  logic signed [TEMP_W-1:0] held;
  logic signed [TEMP_W:0]   upper;
  logic signed [TEMP_W:0]   lower;
  logic signed [TEMP_W:0]   held_x;
  logic                     want_valid;
  logic                     want_on;
  logic [TIME_W-1:0]        elapsed;
  logic                     too_soon;
  logic                     blocked;

  // Qualify the sample against the window
  assign in_window = (item.temperature_sample > cfg.valid_low_bound) &&
                     (item.temperature_sample < cfg.valid_high_bound);

  always_comb begin
    if (!item.read_ok) begin
      status = STATUS_READ_ERR;
      held   = cur.last_good_temp;
    end else if (in_window) begin
      status = STATUS_OK;
      held   = item.temperature_sample;
    end else begin
      status = STATUS_RANGE;
      held   = cur.last_good_temp;
    end
  end

  // Thresholds one bit wider so set point plus band never wraps
  assign held_x = {held[TEMP_W-1], held};
  assign upper  = {cfg.target_temp[TEMP_W-1], cfg.target_temp} +
                  $signed({{(TEMP_W+1-BAND_W){1'b0}}, cfg.hysteresis_band});
  assign lower  = {cfg.target_temp[TEMP_W-1], cfg.target_temp} -
                  $signed({{(TEMP_W+1-BAND_W){1'b0}}, cfg.hysteresis_band});

  // Hysteresis decision
  always_comb begin
    if (!cur.decision_made) begin
      want_valid = 1'b1;
      want_on    = held_x > upper;
    end else if (cur.relay_state) begin
      want_valid = held_x < lower;
      want_on    = 1'b0;
    end else begin
      want_valid = held_x > upper;
      want_on    = 1'b1;
    end
  end

  // Anti short cycle check, modular elapsed time
  assign elapsed  = item.now_seconds - cur.off_timestamp;
  assign too_soon = elapsed < {{(TIME_W-DELAY_W){1'b0}}, cfg.min_off_seconds};
  assign blocked  = want_valid && want_on && cur.off_timestamp_valid && too_soon;

  always_comb begin
    nxt = cur;
    nxt.last_good_temp = held;
    if (want_valid && !blocked) begin
      nxt.relay_state   = want_on;
      nxt.decision_made = 1'b1;
      if (!want_on) begin
        nxt.off_timestamp       = item.now_seconds;
        nxt.off_timestamp_valid = 1'b1;
      end
    end
  end

  assign result.drive_on            = nxt.relay_state;
  assign result.drive_known         = nxt.decision_made;
  assign result.short_cycle_blocked = blocked;
  assign result.sample_status       = status;
  assign result.held_temperature    = held;

endmodule

// File: design/hysteresis_thermostat_anti_short_cycle.sv
// Top level of the hysteresis thermostat with anti short cycle delay.
// Usage:
//   Input channel in_valid / in_stall / in_item carries one sample beat:
//   temperature, read-ok flag and a free running seconds count.
//   Output channel out_valid / out_stall / out_item returns one result beat
//   per sample: relay drive, decision-known flag, blocked flag, sample
//   status and the temperature the decision used.
//   Configuration is written through wr_en / wr_index / wr_data, one
//   register per cycle; the user must write only while no beat is in
//   flight, as the block does not enforce it. Unknown indexes are ignored.
// Timing:
//   A sample lands in an input register, then the decision logic fills the
//   result register. One beat is taken every cycle while in_stall is low;
//   the state update from one sample to the next is combinational compare
//   and subtract logic.
// Reset (rst, synchronous): registers return to their defaults, the held
//   temperature to 512, the relay is undecided and no switch-off is recorded.
// Stall: when the receiver stalls, the result register holds and the input
//   register keeps its beat; in_stall rises only once both are occupied.
module hysteresis_thermostat_anti_short_cycle
  import hts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_index,
  input  logic [CFG_W-1:0]  wr_data
);

  cfg_t       cfg;
  ctl_state_t state;
  ctl_state_t state_next;
  out_item_t  result;
  logic       s1_valid;
  in_item_t   s1_item;
  logic       out_free;
  logic       s1_move;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_temp      <= TARGET_RST;
      cfg.hysteresis_band  <= BAND_RST;
      cfg.valid_low_bound  <= LOW_RST;
      cfg.valid_high_bound <= HIGH_RST;
      cfg.min_off_seconds  <= MIN_OFF_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_TARGET:  cfg.target_temp      <= wr_data[TEMP_W-1:0];
        REG_BAND:    cfg.hysteresis_band  <= wr_data[BAND_W-1:0];
        REG_LOW:     cfg.valid_low_bound  <= wr_data[TEMP_W-1:0];
        REG_HIGH:    cfg.valid_high_bound <= wr_data[TEMP_W-1:0];
        REG_MIN_OFF: cfg.min_off_seconds  <= wr_data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake control
  assign out_free = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item <= in_item;
    end
  end

  hts_decide u_decide (
    .cfg    (cfg),
    .cur    (state),
    .item   (s1_item),
    .nxt    (state_next),
    .result (result)
  );

  // Advance the control state as each beat moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.last_good_temp      <= LOW_RST;
      state.relay_state         <= 1'b0;
      state.decision_made       <= 1'b0;
      state.off_timestamp       <= '0;
      state.off_timestamp_valid <= 1'b0;
    end else if (s1_move) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_item <= result;
    end
  end

  // Checks
  a_on_implies_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_item.drive_on || out_item.drive_known))
    else $error("relay on before any decision");

  a_blocked_is_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.short_cycle_blocked) |-> !out_item.drive_on)
    else $error("blocked switch-on left relay on");

  a_stall_needs_beat: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  a_move_fills_out: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> out_valid)
    else $error("beat lost between input and result register");

  a_status_held: assert property (@(posedge clk) disable iff (rst)
    s1_move && result.sample_status == STATUS_OK |=>
      out_item.held_temperature == $past(s1_item.temperature_sample))
    else $error("accepted sample not held");

endmodule

// File: bench/tb_hysteresis_thermostat_anti_short_cycle.sv
// Self-checking testbench for the hysteresis thermostat with anti short cycle delay.
`timescale 1ns / 1ps

module tb_hysteresis_thermostat_anti_short_cycle;
  import hts_pkg::*;

  localparam int CLK_PERIOD       = 12;
  localparam int RESET_CYCLES     = 12;
  localparam int TIMEOUT_CYCLES   = 400000;
  localparam int PIPE_LATENCY     = 2;
  localparam int LONG_HOLD_CYCLES = 40;
  localparam int PRINT_LIMIT      = 50;

  // First index past the defined registers; writes there must be ignored
  localparam logic [IDX_W-1:0] REG_SPARE_FIRST = REG_MIN_OFF + 3'd1;

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_item;
  logic             wr_en;
  logic [IDX_W-1:0] wr_index;
  logic [CFG_W-1:0] wr_data;

  // Predictor copy of the registers and the control state
  cfg_t       model_cfg;
  ctl_state_t model_ctl;

  out_item_t expected_drive_q[$];

  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          recv_idle_pct  = 0;
  int          hold_requests  = 0;
  int          holds_served   = 0;
  int          stall_left     = 0;
  int          walk_offset    = 0;
  logic [31:0] clock_now      = 32'd0;

  hysteresis_thermostat_anti_short_cycle dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Work out the thermostat result for one sample and advance the predictor state
  function automatic out_item_t predict_thermostat(input in_item_t beat);
    out_item_t         res;
    int                smp, lo, hi, held, tgt, band, upper, lower;
    logic [TIME_W-1:0] elapsed;
    logic [1:0]        status;
    bit                want_on, want_off, blocked;
    smp  = int'($signed(beat.temperature_sample));
    lo   = int'($signed(model_cfg.valid_low_bound));
    hi   = int'($signed(model_cfg.valid_high_bound));
    tgt  = int'($signed(model_cfg.target_temp));
    band = int'(model_cfg.hysteresis_band);
    if (!beat.read_ok) begin
      status = STATUS_READ_ERR;
    end else if (smp > lo && smp < hi) begin
      status = STATUS_OK;
      model_ctl.last_good_temp = beat.temperature_sample;
    end else begin
      status = STATUS_RANGE;
    end
    held  = int'($signed(model_ctl.last_good_temp));
    upper = tgt + band;
    lower = tgt - band;
    want_on  = 1'b0;
    want_off = 1'b0;
    if (!model_ctl.decision_made) begin
      want_on  = held > upper;
      want_off = !(held > upper);
    end else if (model_ctl.relay_state) begin
      want_off = held < lower;
    end else begin
      want_on = held > upper;
    end
    // Elapsed time wraps with the seconds counter
    elapsed = beat.now_seconds - model_ctl.off_timestamp;
    blocked = want_on && model_ctl.off_timestamp_valid &&
              elapsed < {{(TIME_W - DELAY_W){1'b0}}, model_cfg.min_off_seconds};
    if (!blocked && (want_on || want_off)) begin
      model_ctl.relay_state   = want_on;
      model_ctl.decision_made = 1'b1;
      if (want_off) begin
        model_ctl.off_timestamp       = beat.now_seconds;
        model_ctl.off_timestamp_valid = 1'b1;
      end
    end
    res.drive_on            = model_ctl.relay_state;
    res.drive_known         = model_ctl.decision_made;
    res.short_cycle_blocked = blocked;
    res.sample_status       = status;
    res.held_temperature    = model_ctl.last_good_temp;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] due);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, due);
  endtask

  // Offer one sample beat, idling first at the sender's rate, and record its result
  task automatic send_sample(input int temp, input bit ok, input logic [TIME_W-1:0] now);
    in_item_t beat;
    beat.temperature_sample = temp[TEMP_W-1:0];
    beat.read_ok            = ok;
    beat.now_seconds        = now;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_drive_q.push_back(predict_thermostat(beat));
  endtask

  // Drop valid and hold until every pending result has been collected
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  // Write all five registers, preceded by a write to an unused index
  task automatic write_settings(input cfg_t c);
    logic [31:0] rnd;
    rnd = $urandom;
    wr_en    <= 1'b1;
    wr_index <= REG_SPARE_FIRST + IDX_W'(rnd[1:0] % 3);
    wr_data  <= rnd[31:16];
    @(posedge clk);
    wr_index <= REG_TARGET;
    wr_data  <= c.target_temp;
    @(posedge clk);
    // Upper bits of the band write carry junk that must be dropped
    wr_index <= REG_BAND;
    wr_data  <= {rnd[15:8], c.hysteresis_band};
    @(posedge clk);
    wr_index <= REG_LOW;
    wr_data  <= c.valid_low_bound;
    @(posedge clk);
    wr_index <= REG_HIGH;
    wr_data  <= c.valid_high_bound;
    @(posedge clk);
    wr_index <= REG_MIN_OFF;
    wr_data  <= c.min_off_seconds;
    @(posedge clk);
    wr_en <= 1'b0;
    model_cfg = c;
  endtask

  function automatic cfg_t random_settings();
    cfg_t        c;
    int          centre, lo, hi;
    logic [31:0] rnd;
    if ($urandom_range(0, 9) == 0) begin
      // Anything goes, empty or inverted windows included
      rnd = $urandom;
      c.target_temp     = rnd[15:0];
      c.valid_low_bound = rnd[31:16];
      rnd = $urandom;
      c.valid_high_bound = rnd[15:0];
    end else begin
      centre = $urandom_range(0, 3000);
      centre = centre - 1000;
      lo = $urandom_range(20, 600);
      hi = $urandom_range(20, 600);
      lo = centre - lo;
      hi = centre + hi;
      c.target_temp      = centre[15:0];
      c.valid_low_bound  = lo[15:0];
      c.valid_high_bound = hi[15:0];
    end
    case ($urandom_range(0, 7))
      0:       c.hysteresis_band = 8'd0;
      1:       c.hysteresis_band = 8'hff;
      default: begin
        rnd = $urandom_range(1, 40);
        c.hysteresis_band = rnd[7:0];
      end
    endcase
    rnd = $urandom;
    case ($urandom_range(0, 7))
      0:       c.min_off_seconds = 16'd0;
      1:       c.min_off_seconds = 16'hffff;
      2:       c.min_off_seconds = rnd[15:0];
      default: begin
        rnd = $urandom_range(1, 120);
        c.min_off_seconds = rnd[15:0];
      end
    endcase
    return c;
  endfunction

  // Mostly a slow drift of readings across the band with a steady clock, plus
  // samples on the window edges and some random noise
  task automatic run_samples(input int count);
    int                       tgt, lo, hi, band, step, temp, d, pick;
    bit                       ok;
    logic signed [TEMP_W-1:0] raw;
    tgt  = int'($signed(model_cfg.target_temp));
    lo   = int'($signed(model_cfg.valid_low_bound));
    hi   = int'($signed(model_cfg.valid_high_bound));
    band = int'(model_cfg.hysteresis_band);
    step = band / 2 + 4;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
        d = $urandom_range(0, 2 * step);
        walk_offset += d - step;
        if (walk_offset > band + 48) walk_offset = band + 48;
        if (walk_offset < -band - 48) walk_offset = -band - 48;
        temp = tgt + walk_offset;
        if (hi - lo > 1) begin
          if (temp <= lo) temp = lo + 1;
          if (temp >= hi) temp = hi - 1;
        end
        if (temp > 32767) temp = 32767;
        if (temp < -32768) temp = -32768;
        ok = $urandom_range(0, 99) < 94;
        clock_now += $urandom_range(0, 25);
      end else if (pick < 87) begin
        case ($urandom_range(0, 3))
          0:       temp = lo;
          1:       temp = hi;
          2:       temp = lo + 1;
          default: temp = hi - 1;
        endcase
        ok = 1'b1;
        clock_now += $urandom_range(0, 5);
      end else begin
        raw  = TEMP_W'($urandom);
        temp = int'(raw);
        ok   = $urandom_range(0, 1) != 0;
        if ($urandom_range(0, 3) == 0)
          clock_now = $urandom;
        else
          clock_now += $urandom_range(0, 300);
      end
      send_sample(temp, ok, clock_now);
    end
  endtask

  // Reset settings: failed reads, window edges, delay blocking, wrap of the clock
  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_sample(700, 1'b0, 32'd1000);
    send_sample(512, 1'b1, 32'd1001);
    send_sample(2960, 1'b1, 32'd1002);
    send_sample(-32768, 1'b1, 32'd1003);
    send_sample(32767, 1'b1, 32'd1004);
    send_sample(513, 1'b1, 32'd1005);
    send_sample(2959, 1'b1, 32'd1010);
    send_sample(2959, 1'b0, 32'd1059);
    send_sample(2959, 1'b1, 32'd1060);
    send_sample(600, 1'b1, 32'd1070);
    send_sample(599, 1'b1, 32'hffff_fff0);
    send_sample(617, 1'b1, 32'h0000_0010);
    send_sample(616, 1'b1, 32'h0000_0020);
    send_sample(617, 1'b1, 32'h0000_002c);
    send_sample(700, 1'b1, 32'hffff_ffff);
    send_sample(-1, 1'b1, 32'd0);
    send_sample(-1, 1'b0, 32'd0);
    wait_drained();
  endtask

  // Extreme register values: full-scale set point, widest band, empty window,
  // longest delay and zero delay
  task automatic test_config_extremes();
    write_settings('{16'sh7fff, 8'hff, 16'sh8000, 16'sh7fff, 16'd0});
    send_sample(32766, 1'b1, 32'd5000);
    send_sample(-32767, 1'b1, 32'd5001);
    send_sample(32766, 1'b1, 32'd5002);
    send_sample(-32768, 1'b1, 32'd5003);
    send_sample(32767, 1'b1, 32'd5004);
    wait_drained();
    write_settings('{16'sh8000, 8'hff, 16'sh7fff, 16'sh8000, 16'hffff});
    send_sample(0, 1'b1, 32'd5005);
    send_sample(32767, 1'b1, 32'd5006);
    send_sample(-32768, 1'b1, 32'd5007);
    send_sample(100, 1'b0, 32'd5008);
    wait_drained();
    write_settings('{16'sh8000, 8'h00, 16'sh8000, 16'sh7fff, 16'hffff});
    send_sample(-32767, 1'b1, 32'd5100);
    send_sample(-32767, 1'b1, 32'd70535);
    send_sample(-32767, 1'b1, 32'd70536);
    wait_drained();
    write_settings('{16'sh0000, 8'h00, 16'shff9c, 16'sh0064, 16'd0});
    send_sample(-1, 1'b1, 32'd70600);
    send_sample(1, 1'b1, 32'd70600);
    send_sample(0, 1'b1, 32'd70601);
    send_sample(-100, 1'b1, 32'd70602);
    wait_drained();
    clock_now = 32'd70700;
  endtask

  // Hold the result side off for a long stretch while samples keep coming
  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_settings(random_settings());
    hold_requests++;
    run_samples(24);
    wait_drained();
    run_samples(12);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int settings_count, input int per_setting);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (settings_count) begin
      wait_drained();
      write_settings(random_settings());
      run_samples(per_setting);
    end
    wait_drained();
  endtask

  // Drive the result-side stall: a requested long hold first, else random
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served++;
      stall_left = LONG_HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(0, 99) < recv_idle_pct;
    end
  end

  // Compare every accepted result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    out_item_t due;
    if (!rst && out_valid && !out_stall) begin
      if (expected_drive_q.size() == 0) begin
        report_mismatch("result beat with nothing pending", 32'(out_item), 32'd0);
      end else begin
        due = expected_drive_q.pop_front();
        if (out_item.drive_on !== due.drive_on)
          report_mismatch("drive_on", 32'(out_item.drive_on), 32'(due.drive_on));
        if (out_item.drive_known !== due.drive_known)
          report_mismatch("drive_known", 32'(out_item.drive_known),
                          32'(due.drive_known));
        if (out_item.short_cycle_blocked !== due.short_cycle_blocked)
          report_mismatch("short_cycle_blocked", 32'(out_item.short_cycle_blocked),
                          32'(due.short_cycle_blocked));
        if (out_item.sample_status !== due.sample_status)
          report_mismatch("sample_status", 32'(out_item.sample_status),
                          32'(due.sample_status));
        if (out_item.held_temperature !== due.held_temperature)
          report_mismatch("held_temperature", 32'(out_item.held_temperature),
                          32'(due.held_temperature));
      end
    end
  end

  initial begin : run_tests
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_item   = '0;
    out_stall = 1'b0;
    wr_en     = 1'b0;
    wr_index  = REG_TARGET;
    wr_data   = '0;
    model_cfg = '{TARGET_RST, BAND_RST, LOW_RST, HIGH_RST, MIN_OFF_RST};
    // Held temperature starts at the default low bound; no switch-off recorded
    model_ctl = '{LOW_RST, 1'b0, 1'b0, 32'd0, 1'b0};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_config_extremes();
    test_back_pressure();
    test_random_traffic(20, 51, 6, 100);
    test_random_traffic(51, 20, 6, 100);
    test_random_traffic(0, 0, 6, 100);

    repeat (PIPE_LATENCY + 2) @(posedge clk);
    if (mismatch_count == 0 && expected_drive_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("TB_ERROR");
    $finish;
  end

endmodule
